>>> sv/epoch_to_calendar_top_defines.svh
// assertion macros shared by the epoch to calendar rtl
// expects clk and rst in scope at the point of use
`ifndef EPOCH_TO_CALENDAR_TOP_DEFINES_SVH
`define EPOCH_TO_CALENDAR_TOP_DEFINES_SVH

// checked every cycle outside reset
`define ETC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// checked every cycle, reset included
`define ETC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/etc_pkg.sv
// shared types, widths and constant reciprocals for the epoch to calendar pipeline
// no dependencies
package etc_pkg;

  localparam int NSTAGE     = 8;
  localparam int IN_TDATA_W = 56;
  localparam int OUT_TDATA_W = 48;

  localparam int SECS_W  = 32;
  localparam int MICROS_W = 20;
  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int MS_W    = 10;

  localparam int DAYS_W = 16;
  localparam int DOE_W  = 18;
  localparam int YOE_W  = 9;
  localparam int DOY_W  = 9;
  localparam int MP_W   = 4;
  localparam int REM_W  = 17;
  localparam int R2_W   = 12;

  localparam int SECS_PER_DAY  = 86400;
  localparam int SECS_PER_HOUR = 3600;
  localparam int SECS_PER_MIN  = 60;
  localparam int MILLIS_MAX    = 999;

  // day shift to a march-based calendar and era bounds
  localparam int DAY_SHIFT  = 719468;
  localparam int ERA_DAYS   = 146097;
  localparam int ERA4_START = 4 * ERA_DAYS;
  localparam int ERA5_START = 5 * ERA_DAYS;
  localparam int CENT_DAYS  = 36524;
  localparam int YEAR_DAYS  = 365;

  // reciprocals m = ceil(2^k / d), k = bits(x) + bits(d), exact for every x
  localparam int DAY_K  = 35;  // (secs >> 7) / 675
  localparam int HOUR_K = 21;  // (rem >> 4) / 225
  localparam int MIN_K  = 14;  // (r2 >> 2) / 15
  localparam int MS_K   = 24;  // (us >> 3) / 125
  localparam int Q4Y_K  = 25;  // (doe >> 2) / 365
  localparam int YOE_K  = 27;  // t / 365
  localparam int MP_K   = 19;  // (5 * doy + 2) / 153

  localparam longint unsigned DAY_RECIP  = ((64'd1 << DAY_K) + 64'd674) / 64'd675;
  localparam longint unsigned HOUR_RECIP = ((64'd1 << HOUR_K) + 64'd224) / 64'd225;
  localparam longint unsigned MIN_RECIP  = ((64'd1 << MIN_K) + 64'd14) / 64'd15;
  localparam longint unsigned MS_RECIP   = ((64'd1 << MS_K) + 64'd124) / 64'd125;
  localparam longint unsigned Q4Y_RECIP  = ((64'd1 << Q4Y_K) + 64'd364) / 64'd365;
  localparam longint unsigned YOE_RECIP  = ((64'd1 << YOE_K) + 64'd364) / 64'd365;
  localparam longint unsigned MP_RECIP   = ((64'd1 << MP_K) + 64'd152) / 64'd153;

  typedef struct packed {
    logic [MS_W-1:0]   millis;
    logic [SEC_W-1:0]  second;
    logic [MIN_W-1:0]  minute;
    logic [HOUR_W-1:0] hour;
  } etc_tod_t;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } etc_date_t;

  // first day of year of each march-based month, (153 * mp + 2) / 5
  function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
    logic [DOY_W-1:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

>>> sv/etc_time_split.sv
// splits seconds into day count and time of day, microseconds into millis
// uses etc_pkg; stage enables come from the top level valid chain
module etc_time_split (
  input  logic                          clk,
  input  logic [etc_pkg::NSTAGE-1:0]    en,
  input  logic [etc_pkg::SECS_W-1:0]    secs,
  input  logic [etc_pkg::MICROS_W-1:0]  micros,
  output logic [etc_pkg::DAYS_W-1:0]    days,
  output etc_pkg::etc_tod_t             tod
);
  import etc_pkg::*;

  // stage 2: day count and millis by reciprocal
  logic [50:0] day_prod;
  logic [34:0] ms_prod;
  logic [10:0] ms_raw;
  logic [MS_W-1:0] ms_sat;

  logic [SECS_W-1:0] secs_s2;
  logic [MS_W-1:0]   ms_s2;

  assign day_prod = 51'(secs[SECS_W-1:7]) * 51'(26'(DAY_RECIP));
  assign ms_prod  = 35'(micros[MICROS_W-1:3]) * 35'(18'(MS_RECIP));
  assign ms_raw   = ms_prod[MS_K +: 11];
  assign ms_sat   = (ms_raw > 11'(MILLIS_MAX)) ? MS_W'(MILLIS_MAX) : ms_raw[MS_W-1:0];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      secs_s2 <= secs;
      days    <= day_prod[DAY_K +: DAYS_W];
      ms_s2   <= ms_sat;
    end
  end

  // stage 3: seconds within the day
  logic [32:0] day_secs;
  logic [REM_W-1:0] rem_s3;
  logic [MS_W-1:0]  ms_s3;

  assign day_secs = 33'(days) * 33'(SECS_PER_DAY);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      rem_s3 <= secs_s2[REM_W-1:0] - day_secs[REM_W-1:0];
      ms_s3  <= ms_s2;
    end
  end

  // stage 4: hour
  logic [26:0] hr_prod;
  logic [REM_W-1:0]  rem_s4;
  logic [HOUR_W-1:0] hr_s4;
  logic [MS_W-1:0]   ms_s4;

  assign hr_prod = 27'(rem_s3[REM_W-1:4]) * 27'(14'(HOUR_RECIP));

  always_ff @(posedge clk) begin
    if (en[3]) begin
      rem_s4 <= rem_s3;
      hr_s4  <= hr_prod[HOUR_K +: HOUR_W];
      ms_s4  <= ms_s3;
    end
  end

  // stage 5: seconds within the hour
  logic [REM_W-1:0]  hr_secs;
  logic [R2_W-1:0]   r2_s5;
  logic [HOUR_W-1:0] hr_s5;
  logic [MS_W-1:0]   ms_s5;

  assign hr_secs = REM_W'(hr_s4) * REM_W'(SECS_PER_HOUR);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      r2_s5 <= R2_W'(rem_s4 - hr_secs);
      hr_s5 <= hr_s4;
      ms_s5 <= ms_s4;
    end
  end

  // stage 6: minute
  logic [20:0] mn_prod;
  logic [R2_W-1:0]   r2_s6;
  logic [MIN_W-1:0]  mn_s6;
  logic [HOUR_W-1:0] hr_s6;
  logic [MS_W-1:0]   ms_s6;

  assign mn_prod = 21'(r2_s5[R2_W-1:2]) * 21'(11'(MIN_RECIP));

  always_ff @(posedge clk) begin
    if (en[5]) begin
      r2_s6 <= r2_s5;
      mn_s6 <= mn_prod[MIN_K +: MIN_W];
      hr_s6 <= hr_s5;
      ms_s6 <= ms_s5;
    end
  end

  // stage 7: second
  logic [R2_W-1:0] mn_secs;

  assign mn_secs = R2_W'(mn_s6) * R2_W'(SECS_PER_MIN);

  always_ff @(posedge clk) begin
    if (en[6]) begin
      tod.second <= SEC_W'(r2_s6 - mn_secs);
      tod.minute <= mn_s6;
      tod.hour   <= hr_s6;
      tod.millis <= ms_s6;
    end
  end

endmodule

>>> sv/etc_civil_date.sv
// turns a day count since 1970-01-01 into gregorian year, month and day
// uses etc_pkg; runs in stages 3 to 7 of the top level pipeline
module etc_civil_date (
  input  logic                        clk,
  input  logic [etc_pkg::NSTAGE-1:0]  en,
  input  logic [etc_pkg::DAYS_W-1:0]  days,
  output etc_pkg::etc_date_t          date
);
  import etc_pkg::*;

  // stage 3: era and day of era, counted from a march 1 origin
  logic [19:0] z;
  logic        era_hi;
  logic [DOE_W-1:0] doe_s3;
  logic             era_s3;

  assign z      = 20'(days) + 20'(DAY_SHIFT);
  assign era_hi = (z >= 20'(ERA5_START));

  always_ff @(posedge clk) begin
    if (en[2]) begin
      doe_s3 <= DOE_W'(z - (era_hi ? 20'(ERA5_START) : 20'(ERA4_START)));
      era_s3 <= era_hi;
    end
  end

  // stage 4: day of era with leap days taken out
  logic [32:0] q4y_prod;
  logic [6:0]  q4y;
  logic [2:0]  qcent;
  logic        qlast;
  logic [DOE_W-1:0] t_s4;
  logic [DOE_W-1:0] doe_s4;
  logic             era_s4;

  assign q4y_prod = 33'(doe_s3[DOE_W-1:2]) * 33'(17'(Q4Y_RECIP));
  assign q4y      = q4y_prod[Q4Y_K +: 7];
  assign qcent    = 3'(doe_s3 >= DOE_W'(CENT_DAYS)) + 3'(doe_s3 >= DOE_W'(2 * CENT_DAYS))
                  + 3'(doe_s3 >= DOE_W'(3 * CENT_DAYS)) + 3'(doe_s3 >= DOE_W'(4 * CENT_DAYS));
  assign qlast    = (doe_s3 == DOE_W'(ERA_DAYS - 1));

  always_ff @(posedge clk) begin
    if (en[3]) begin
      t_s4   <= doe_s3 - DOE_W'(q4y) + DOE_W'(qcent) - DOE_W'(qlast);
      doe_s4 <= doe_s3;
      era_s4 <= era_s3;
    end
  end

  // stage 5: year of era
  logic [36:0] yoe_prod;
  logic [YOE_W-1:0] yoe_s5;
  logic [DOE_W-1:0] doe_s5;
  logic             era_s5;

  assign yoe_prod = 37'(t_s4) * 37'(19'(YOE_RECIP));

  always_ff @(posedge clk) begin
    if (en[4]) begin
      yoe_s5 <= yoe_prod[YOE_K +: YOE_W];
      doe_s5 <= doe_s4;
      era_s5 <= era_s4;
    end
  end

  // stage 6: day of march-based year
  logic [1:0]       ycent;
  logic [DOE_W-1:0] year_base;
  logic [DOY_W-1:0] doy_s6;
  logic [YOE_W-1:0] yoe_s6;
  logic             era_s6;

  assign ycent = 2'(yoe_s5 >= 9'd100) + 2'(yoe_s5 >= 9'd200) + 2'(yoe_s5 >= 9'd300);
  assign year_base = DOE_W'(yoe_s5) * DOE_W'(YEAR_DAYS) + DOE_W'(yoe_s5[YOE_W-1:2])
                   - DOE_W'(ycent);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      doy_s6 <= DOY_W'(doe_s5 - year_base);
      yoe_s6 <= yoe_s5;
      era_s6 <= era_s5;
    end
  end

  // stage 7: march-based month index
  logic [10:0] mp_num;
  logic [22:0] mp_prod;
  logic [MP_W-1:0]  mp_s7;
  logic [DOY_W-1:0] doy_s7;
  logic [YOE_W-1:0] yoe_s7;
  logic             era_s7;

  assign mp_num  = 11'(doy_s6) * 11'd5 + 11'd2;
  assign mp_prod = 23'(mp_num) * 23'(12'(MP_RECIP));

  always_ff @(posedge clk) begin
    if (en[6]) begin
      mp_s7  <= mp_prod[MP_K +: MP_W];
      doy_s7 <= doy_s6;
      yoe_s7 <= yoe_s6;
      era_s7 <= era_s6;
    end
  end

  // output: day, civil month and year, january and february belong to the next year
  logic [MONTH_W-1:0] mon;

  assign mon = (mp_s7 < 4'd10) ? mp_s7 + 4'd3 : mp_s7 - 4'd9;

  always_comb begin
    date.day   = DAY_W'(doy_s7 - month_start(mp_s7) + 9'd1);
    date.month = mon;
    date.year  = YEAR_W'(yoe_s7) + (era_s7 ? 12'd2000 : 12'd1600)
               + YEAR_W'(mon <= 4'd2);
  end

endmodule

>>> sv/epoch_to_calendar_top.sv
// epoch to calendar top level: stream ports, input and output registers, stage valid chain
// uses etc_pkg, etc_time_split, etc_civil_date and epoch_to_calendar_top_defines.svh
//
//   channel   dir   tdata fields (low bit first)                         beat
//   s_axis    in    epoch_seconds[31:0] micros[51:32] zero[55:52]        one timestamp
//   m_axis    out   year[11:0] month[15:12] day[20:16] hour[25:21]      one calendar result
//                   minute[31:26] second[37:32] millis[47:38]
//
// one beat in and one beat out per cycle while m_axis is ready; an accepted beat passes
// through all eight register stages, the input register first and the output register last
// rst clears the stage valid bits only, data registers need no reset
// each stage loads when it is empty or when the stage after it moves, so bubbles close up
// s_axis_tready drops only when all eight stages hold beats and m_axis is stalled
`include "epoch_to_calendar_top_defines.svh"

module epoch_to_calendar_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // epoch_seconds[31:0], micros[51:32], zero fill[55:52]
  input  logic [etc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // year[11:0], month[15:12], day[20:16], hour[25:21], minute[31:26],
  // second[37:32], millis[47:38]
  output logic [etc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import etc_pkg::*;

  // stage valid bits, vld[0] is the input register, vld[NSTAGE-1] the output register
  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] en;

  // a stage loads when empty or when its successor moves on
  always_comb begin
    en[NSTAGE-1] = !vld[NSTAGE-1] || m_axis_tready;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NSTAGE; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // input register
  logic [SECS_W-1:0]   secs_s1;
  logic [MICROS_W-1:0] micros_s1;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      secs_s1   <= s_axis_tdata[SECS_W-1:0];
      micros_s1 <= s_axis_tdata[SECS_W +: MICROS_W];
    end
  end

  // day count and time of day
  logic [DAYS_W-1:0] days;
  etc_tod_t          tod;

  etc_time_split u_time_split (
    .clk    (clk),
    .en     (en),
    .secs   (secs_s1),
    .micros (micros_s1),
    .days   (days),
    .tod    (tod)
  );

  // calendar date from the day count
  etc_date_t date;

  etc_civil_date u_civil_date (
    .clk  (clk),
    .en   (en),
    .days (days),
    .date (date)
  );

  // output register, holds while m_axis is stalled
  etc_tod_t  out_tod;
  etc_date_t out_date;

  always_ff @(posedge clk) begin
    if (en[NSTAGE-1]) begin
      out_tod  <= tod;
      out_date <= date;
    end
  end

  assign m_axis_tdata = {out_tod.millis, out_tod.second, out_tod.minute, out_tod.hour,
                         out_date.day, out_date.month, out_date.year};

  // a full pipeline with m_axis stalled is the only reason to refuse a beat
  `ETC_ASSERT(a_ready_low_full,
    !s_axis_tready |-> (&vld && !m_axis_tready),
    "ready low with room in pipeline")
  // reset empties every stage
  `ETC_ASSERT_ALWAYS(a_reset_empty,
    rst |=> (!m_axis_tvalid && s_axis_tready),
    "pipeline not empty after reset")
  // date fields stay in calendar range
  `ETC_ASSERT(a_date_range,
    m_axis_tvalid |-> (out_date.month >= 4'd1 && out_date.month <= 4'd12 &&
                       out_date.day >= 5'd1 && out_date.year >= 12'd1970 &&
                       out_date.year <= 12'd2106),
    "date field out of range")
  // time fields stay in clock range
  `ETC_ASSERT(a_time_range,
    m_axis_tvalid |-> (out_tod.hour <= 5'd23 && out_tod.minute <= 6'd59 &&
                       out_tod.second <= 6'd59 && out_tod.millis <= 10'd999),
    "time field out of range")

endmodule

>>> bench/tb.sv
// self-checking bench for epoch_to_calendar_top: drives timestamps on s_axis, checks calendar
// results on m_axis against a behavioral predictor or hand-written rows; needs etc_pkg and the rtl only
module tb;

  import etc_pkg::*;

  // run limits
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_BEATS = 750;
  localparam int SEGMENT_LEN  = 50;   // random beats per idling segment
  localparam int HOLD_CYCLES  = 250;  // long m_axis back-pressure
  localparam int HOLD_BURST   = 40;   // beats offered while m_axis is held off
  localparam int DRAIN_CYCLES = 16;   // pipeline is eight stages deep
  localparam int FILL_W       = IN_TDATA_W - SECS_W - MICROS_W;

  // one calendar result, laid out as m_axis_tdata (year in the low bits)
  typedef struct packed {
    logic [MS_W-1:0]    millis;
    logic [SEC_W-1:0]   second;
    logic [MIN_W-1:0]   minute;
    logic [HOUR_W-1:0]  hour;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } calendar_t;

  // one timestamp beat; pinned rows carry a hand-written calendar result
  typedef struct {
    logic [SECS_W-1:0]   secs;
    logic [MICROS_W-1:0] us;
    logic                pinned;
    calendar_t           lit;
  } stamp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // epoch_seconds[31:0], micros[51:32], zero fill[55:52]
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // year[11:0], month[15:12], day[20:16], hour[25:21], minute[31:26],
  // second[37:32], millis[47:38]
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  epoch_to_calendar_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // stamps offered but not yet accepted, and calendar results still owed
  stamp_t    offered_stamp_q[$];
  calendar_t owed_calendar_q[$];

  int unsigned cycle_cnt    = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned result_cnt   = 0;
  int unsigned leap_day_cnt = 0;
  int unsigned sat_ms_cnt   = 0;
  int unsigned directed_cnt = 0;

  // coordination between the sender and the m_axis ready process
  bit calm_mode   = 1'b0;  // neither side idles
  bit hold_go     = 1'b0;  // sender asks for the long hold-off
  bit hold_active = 1'b0;  // ready process has started it

  calendar_t got_cal;
  calendar_t want_cal;
  stamp_t    acc_stamp;

  always #5 clk = ~clk;

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("epoch_to_calendar_top verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // calendar predictor: walk whole years from 1970, then whole months
  // ---------------------------------------------------------------------------
  function automatic bit is_leap_year(input int unsigned yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  function automatic calendar_t calc_calendar(input logic [SECS_W-1:0] secs,
                                              input logic [MICROS_W-1:0] us);
    calendar_t   c;
    int unsigned s;
    int unsigned day_num;
    int unsigned sod;
    int unsigned yr;
    int unsigned mo;
    int unsigned ylen;
    int unsigned mlen;
    int unsigned ms;
    s       = secs;
    day_num = s / SECS_PER_DAY;
    sod     = s % SECS_PER_DAY;
    yr      = 1970;
    ylen    = is_leap_year(yr) ? 366 : 365;
    while (day_num >= ylen) begin
      day_num = day_num - ylen;
      yr      = yr + 1;
      ylen    = is_leap_year(yr) ? 366 : 365;
    end
    mo = 1;
    forever begin
      case (mo)
        2:           mlen = is_leap_year(yr) ? 29 : 28;
        4, 6, 9, 11: mlen = 30;
        default:     mlen = 31;
      endcase
      if (day_num < mlen) break;
      day_num = day_num - mlen;
      mo      = mo + 1;
    end
    ms = int'(us) / 1000;
    if (ms > MILLIS_MAX) ms = MILLIS_MAX;  // micros past 999999 saturate
    c.year   = YEAR_W'(yr);
    c.month  = MONTH_W'(mo);
    c.day    = DAY_W'(day_num + 1);
    c.hour   = HOUR_W'(sod / SECS_PER_HOUR);
    c.minute = MIN_W'((sod % SECS_PER_HOUR) / SECS_PER_MIN);
    c.second = SEC_W'(sod % SECS_PER_MIN);
    c.millis = MS_W'(ms);
    return c;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_cnt++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // monitor: on an s_axis beat queue what is owed, on an m_axis beat compare
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        acc_stamp = offered_stamp_q.pop_front();
        owed_calendar_q.push_back(acc_stamp.pinned ? acc_stamp.lit
                                                   : calc_calendar(acc_stamp.secs, acc_stamp.us));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_cal = m_axis_tdata;
        result_cnt++;
        if (owed_calendar_q.size() == 0) begin
          $error("m_axis beat with no result owed: %h", m_axis_tdata);
          mismatch_cnt++;
        end else begin
          want_cal = owed_calendar_q.pop_front();
          if (want_cal.month == 2 && want_cal.day == 29) leap_day_cnt++;
          if (want_cal.millis == MILLIS_MAX) sat_ms_cnt++;
          check_field("year",   32'(want_cal.year),   32'(got_cal.year));
          check_field("month",  32'(want_cal.month),  32'(got_cal.month));
          check_field("day",    32'(want_cal.day),    32'(got_cal.day));
          check_field("hour",   32'(want_cal.hour),   32'(got_cal.hour));
          check_field("minute", 32'(want_cal.minute), 32'(got_cal.minute));
          check_field("second", 32'(want_cal.second), 32'(got_cal.second));
          check_field("millis", 32'(want_cal.millis), 32'(got_cal.millis));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // m_axis ready: random stalls, one long hold-off on request, none in calm mode
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned r;
    int unsigned span;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_go && !hold_active) begin
        hold_active = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (calm_mode) begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          span = $urandom_range(1, 20);
          m_axis_tready <= 1'b1;
        end else begin
          if (r < 85)      span = $urandom_range(1, 3);
          else if (r < 95) span = $urandom_range(4, 10);
          else             span = $urandom_range(20, 60);
          m_axis_tready <= 1'b0;
        end
        repeat (span) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------------
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm_mode) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [SECS_W-1:0] draw_secs();
    int unsigned r;
    int unsigned d;
    r = $urandom_range(0, 99);
    if (r < 45) return $urandom;
    d = $urandom_range(0, 49709);
    // close to midnight on either side
    if (r < 75) return d * SECS_PER_DAY + ($urandom_range(0, 1) ? $urandom_range(0, 3)
                                                                : SECS_PER_DAY - 1 -
                                                                  $urandom_range(0, 3));
    // last few hundred days before the 32-bit wrap
    if (r < 85) return 32'hFFFF_FFFF - $urandom_range(0, 400 * SECS_PER_DAY);
    return d * SECS_PER_DAY + $urandom_range(0, SECS_PER_DAY - 1);
  endfunction

  function automatic logic [MICROS_W-1:0] draw_micros();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return MICROS_W'($urandom_range(0, 999999));
    if (r < 92) return MICROS_W'($urandom_range(1000000, (1 << MICROS_W) - 1));
    // right on or just below a millisecond edge
    return MICROS_W'($urandom_range(0, 999) * 1000 + ($urandom_range(0, 1) ? 0 : 999));
  endfunction

  // offer one beat after an optional gap and wait for its handshake
  task automatic send_stamp(input stamp_t st, input int unsigned gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    offered_stamp_q.push_back(st);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{FILL_W{1'b0}}, st.us, st.secs};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  initial begin
    stamp_t    dir_tab[$];
    stamp_t    st;
    calendar_t none;
    none = '0;

    // epoch origin and the micros extremes, saturation above 999999
    dir_tab.push_back('{secs: 32'd0, us: 20'd0, pinned: 1'b1,
      lit: '{year: 12'd1970, month: 4'd1, day: 5'd1, hour: 5'd0, minute: 6'd0,
             second: 6'd0, millis: 10'd0}});
    dir_tab.push_back('{secs: 32'd0, us: 20'd999999, pinned: 1'b1,
      lit: '{year: 12'd1970, month: 4'd1, day: 5'd1, hour: 5'd0, minute: 6'd0,
             second: 6'd0, millis: 10'd999}});
    dir_tab.push_back('{secs: 32'd0, us: 20'd1000000, pinned: 1'b1,
      lit: '{year: 12'd1970, month: 4'd1, day: 5'd1, hour: 5'd0, minute: 6'd0,
             second: 6'd0, millis: 10'd999}});
    dir_tab.push_back('{secs: 32'd0, us: 20'hFFFFF, pinned: 1'b1,
      lit: '{year: 12'd1970, month: 4'd1, day: 5'd1, hour: 5'd0, minute: 6'd0,
             second: 6'd0, millis: 10'd999}});
    // largest timestamp
    dir_tab.push_back('{secs: 32'hFFFF_FFFF, us: 20'hFFFFF, pinned: 1'b1,
      lit: '{year: 12'd2106, month: 4'd2, day: 5'd7, hour: 5'd6, minute: 6'd28,
             second: 6'd15, millis: 10'd999}});
    dir_tab.push_back('{secs: 32'hFFFF_FFFF, us: 20'd0, pinned: 1'b1,
      lit: '{year: 12'd2106, month: 4'd2, day: 5'd7, hour: 5'd6, minute: 6'd28,
             second: 6'd15, millis: 10'd0}});
    // end of the first day and the start of the second
    dir_tab.push_back('{secs: 32'd86399, us: 20'd1000, pinned: 1'b1,
      lit: '{year: 12'd1970, month: 4'd1, day: 5'd1, hour: 5'd23, minute: 6'd59,
             second: 6'd59, millis: 10'd1}});
    dir_tab.push_back('{secs: 32'd86400, us: 20'd999, pinned: 1'b1,
      lit: '{year: 12'd1970, month: 4'd1, day: 5'd2, hour: 5'd0, minute: 6'd0,
             second: 6'd0, millis: 10'd0}});
    // century leap day, new year 2000, signed 32-bit rollover, one billion
    dir_tab.push_back('{secs: 32'd951782400, us: 20'd500000, pinned: 1'b1,
      lit: '{year: 12'd2000, month: 4'd2, day: 5'd29, hour: 5'd0, minute: 6'd0,
             second: 6'd0, millis: 10'd500}});
    dir_tab.push_back('{secs: 32'd946684800, us: 20'd0, pinned: 1'b1,
      lit: '{year: 12'd2000, month: 4'd1, day: 5'd1, hour: 5'd0, minute: 6'd0,
             second: 6'd0, millis: 10'd0}});
    dir_tab.push_back('{secs: 32'd2147483647, us: 20'd123456, pinned: 1'b1,
      lit: '{year: 12'd2038, month: 4'd1, day: 5'd19, hour: 5'd3, minute: 6'd14,
             second: 6'd7, millis: 10'd123}});
    dir_tab.push_back('{secs: 32'd1000000000, us: 20'd0, pinned: 1'b1,
      lit: '{year: 12'd2001, month: 4'd9, day: 5'd9, hour: 5'd1, minute: 6'd46,
             second: 6'd40, millis: 10'd0}});
    // the rest go through the predictor
    dir_tab.push_back('{secs: 32'd951868800,  us: 20'd0,      pinned: 1'b0, lit: none});
    dir_tab.push_back('{secs: 32'd68169599,   us: 20'd999000, pinned: 1'b0, lit: none});
    dir_tab.push_back('{secs: 32'd4107542399, us: 20'd1,      pinned: 1'b0, lit: none});
    dir_tab.push_back('{secs: 32'd4107542400, us: 20'd1000,   pinned: 1'b0, lit: none});
    dir_tab.push_back('{secs: 32'd31535999,   us: 20'd999,    pinned: 1'b0, lit: none});
    dir_tab.push_back('{secs: 32'd31536000,   us: 20'd1999,   pinned: 1'b0, lit: none});
    dir_tab.push_back('{secs: 32'h8000_0000,  us: 20'h80000,  pinned: 1'b0, lit: none});
    dir_tab.push_back('{secs: 32'h5555_5555,  us: 20'h55555,  pinned: 1'b0, lit: none});
    dir_tab.push_back('{secs: 32'hAAAA_AAAA,  us: 20'hAAAAA,  pinned: 1'b0, lit: none});

    @(posedge clk);
    while (rst) @(posedge clk);

    foreach (dir_tab[i]) begin
      send_stamp(dir_tab[i], draw_gap());
      directed_cnt++;
    end

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      // idling style changes per segment, some segments fully back-to-back
      if (n % SEGMENT_LEN == 0) calm_mode = ($urandom_range(0, 3) == 0);

      // sender goes quiet until every owed result is back
      if (n == 150) begin
        s_axis_tvalid <= 1'b0;
        while (offered_stamp_q.size() != 0 || owed_calendar_q.size() != 0) @(posedge clk);
      end

      // long m_axis hold-off while beats keep coming, so s_axis_tready drops
      if (n == 300) begin
        s_axis_tvalid <= 1'b0;
        hold_go = 1'b1;
        while (!hold_active) @(posedge clk);
        for (int k = 0; k < HOLD_BURST; k++) begin
          st = '{secs: draw_secs(), us: draw_micros(), pinned: 1'b0, lit: none};
          send_stamp(st, 0);
        end
      end

      st = '{secs: draw_secs(), us: draw_micros(), pinned: 1'b0, lit: none};
      send_stamp(st, draw_gap());
    end
    s_axis_tvalid <= 1'b0;
    calm_mode = 1'b0;

    while (offered_stamp_q.size() != 0 || owed_calendar_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("converted %0d timestamps (%0d directed rows, rest random with stalls and one long",
             result_cnt, directed_cnt);
    $display("hold-off); %0d leap days and %0d saturated or top millis seen",
             leap_day_cnt, sat_ms_cnt);
    if (mismatch_cnt == 0) begin
      $display("epoch_to_calendar_top verification clean");
    end else begin
      $display("epoch_to_calendar_top verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/etc_pkg.sv
sv/etc_time_split.sv
sv/etc_civil_date.sv
sv/epoch_to_calendar_top.sv
bench/tb.sv
